FILE: rtl/core/ltm_pkg.sv
// shared types and constants for the luma tone mapper
// no dependencies

package ltm_pkg;

    localparam int LUMA_W   = 8;
    localparam int OUT_W    = 16;
    localparam int CFG_W    = 16;
    localparam int APB_W    = 32;
    localparam int ADDR_W   = 5;
    localparam int REG_IDX_W = 3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_EXPOSURE_GAIN    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SHADOW_ENABLE    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SHADOW_LIFT      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HIGHLIGHT_ENABLE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HIGHLIGHT_KNEE   = 3'd4;

    // reset values
    localparam logic [CFG_W-1:0] GAIN_RST = 16'd4096;
    localparam logic [CFG_W-1:0] LIFT_RST = 16'd4096;
    localparam logic [CFG_W-1:0] KNEE_RST = 16'd52429;

    // exposure gain floor, about 0.1 in q4.12
    localparam logic [CFG_W-1:0] GAIN_MIN = 16'd410;

    // rounding half of the divide by the 255 full-scale code
    localparam logic [6:0]        LUMA_ROUND = 7'd127;

    // reciprocals of 255, exact for 24-bit and 20-bit dividends
    localparam logic [24:0] RECIP_255_24 = 25'd16843010;
    localparam logic [20:0] RECIP_255_20 = 21'd1052689;

    // 255.0 in q8.8
    localparam logic [OUT_W-1:0] OUT_SCALE = 16'd65280;

    typedef struct packed {
        logic [LUMA_W-1:0] luma_in;
        logic              frame_end_in;
    } pix_in_t;

    typedef struct packed {
        logic [OUT_W-1:0] luma_out;
        logic             frame_end_out;
    } pix_out_t;

endpackage

FILE: rtl/core/ltm_div.sv
// pipelined restoring divider, one quotient bit per stage, with a side tag
// standalone, no package needed

module ltm_div #(
    parameter int NW = 32,
    parameter int DW = 16,
    parameter int QW = 16,
    parameter int PW = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [PW-1:0] tag_in,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [PW-1:0] tag_out
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [CW-1:0] rem_reg [QW-1];
    logic [DW-1:0] den_reg [QW-1];
    logic [QW-1:0] quo_reg [QW];
    logic [PW-1:0] tag_reg [QW];
    logic          vld_reg [QW];

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [CW-1:0] stg_rem;
        logic [DW-1:0] stg_den;
        logic [QW-1:0] stg_quo;
        logic [PW-1:0] stg_tag;
        logic          stg_vld;
        logic [CW-1:0] trial;
        logic          fits;

        if (i == 0)
        begin : g_head
            assign stg_rem = CW'(num);
            assign stg_den = den;
            assign stg_quo = '0;
            assign stg_tag = tag_in;
            assign stg_vld = in_valid;
        end
        else
        begin : g_body
            assign stg_rem = rem_reg[i-1];
            assign stg_den = den_reg[i-1];
            assign stg_quo = quo_reg[i-1];
            assign stg_tag = tag_reg[i-1];
            assign stg_vld = vld_reg[i-1];
        end

        assign trial = CW'(stg_den) << (QW - 1 - i);
        assign fits  = stg_rem >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else
            begin
                vld_reg[i] <= stg_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            quo_reg[i] <= stg_quo | (QW'(fits) << (QW - 1 - i));
            tag_reg[i] <= stg_tag;
        end

        if (i < QW - 1)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                rem_reg[i] <= fits ? (stg_rem - trial) : stg_rem;
                den_reg[i] <= stg_den;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign tag_out   = tag_reg[QW-1];

endmodule

FILE: rtl/core/ltm_shadow.sv
// rational shadow lift below 0.45, fixed latency whether enabled or not
// depends on ltm_pkg and ltm_div

module ltm_shadow
    import ltm_pkg::*;
#(
    parameter int F = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [F+4:0]     in_x,
    input  logic             in_fe,
    input  logic             enable,
    input  logic [CFG_W-1:0] lift,
    output logic             out_valid,
    output logic [F+4:0]     out_x,
    output logic             out_fe
);

    localparam int XW = F + 5;
    localparam int TW = XW + F + 3;
    localparam longint unsigned ONE_L = 64'd1 << F;
    localparam longint unsigned K45_L = ((64'd45 << F) + 64'd50) / 64'd100;
    localparam longint unsigned K12_L = ((64'd12 << F) + 64'd50) / 64'd100;
    localparam longint unsigned K22_L = ((64'd22 << F) + 64'd50) / 64'd100;
    localparam longint unsigned K45_INV_L = (64'd1 << (2*F)) / K45_L;
    localparam logic [F-1:0] K45 = F'(K45_L);
    localparam logic [F-1:0] K12 = F'(K12_L);
    localparam logic [F-1:0] K22 = F'(K22_L);
    localparam logic [F-1:0] HALF = F'(ONE_L >> 1);
    localparam logic [F+1:0] K45_INV = (F+2)'(K45_INV_L);
    localparam logic [F:0]   K45_X2  = (F+1)'(K45_L << 1);

    // lift times 0.22, refreshed from the register every cycle
    logic [F+15:0] lift_prod;
    logic [F+1:0]  p_reg;

    assign lift_prod = (F+16)'(lift) * (F+16)'(K22);

    always_ff @(posedge clk)
    begin
        p_reg <= (F+2)'(((F+16)'(lift_prod) + (F+16)'(2048)) >> 12);
    end

    // stage 1: bypass decision, ratio dividend, reciprocal estimate of (0.45-x)/0.45
    logic           byp;
    logic [F-1:0]   x_lo;
    logic [F-1:0]   y;
    logic [2*F+1:0] est;
    logic [F-1:0]   r_den;
    logic [2*F:0]   r_num;

    assign byp    = !enable || (in_x == '0) || (in_x >= XW'(K45)) || (lift == '0);
    assign x_lo   = in_x[F-1:0];
    assign y      = byp ? '0 : (K45 - x_lo);
    assign est    = (2*F+2)'(y) * (2*F+2)'(K45_INV);
    assign r_den  = x_lo + K12;
    assign r_num  = byp ? '0 :
                    ((2*F+1)'({x_lo, {F{1'b0}}}) + (2*F+1)'(r_den >> 1));

    logic          s1_vld_reg;
    logic [XW-1:0] s1_x_reg;
    logic          s1_fe_reg;
    logic          s1_byp_reg;
    logic [F-1:0]  s1_y_reg;
    logic [F:0]    s1_q_reg;
    logic [2*F:0]  s1_r_num_reg;
    logic [F-1:0]  s1_r_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_x_reg     <= in_x;
        s1_fe_reg    <= in_fe;
        s1_byp_reg   <= byp;
        s1_y_reg     <= y;
        s1_q_reg     <= (F+1)'(est >> F);
        s1_r_num_reg <= r_num;
        s1_r_den_reg <= r_den;
    end

    // stage 2: remainder of the estimate, at most two divisors short
    logic [2*F:0] n_full;
    logic [2*F:0] n_back;
    logic [2*F:0] n_rem;

    assign n_full = (2*F+1)'({s1_y_reg, {F{1'b0}}}) + (2*F+1)'(K45 >> 1);
    assign n_back = (2*F+1)'(s1_q_reg) * (2*F+1)'(K45);
    assign n_rem  = n_full - n_back;

    logic          s2_vld_reg;
    logic [XW-1:0] s2_x_reg;
    logic          s2_fe_reg;
    logic          s2_byp_reg;
    logic [F:0]    s2_q_reg;
    logic [F:0]    s2_rem_reg;
    logic [2*F:0]  s2_r_num_reg;
    logic [F-1:0]  s2_r_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_x_reg     <= s1_x_reg;
        s2_fe_reg    <= s1_fe_reg;
        s2_byp_reg   <= s1_byp_reg;
        s2_q_reg     <= s1_q_reg;
        s2_rem_reg   <= n_rem[F:0];
        s2_r_num_reg <= s1_r_num_reg;
        s2_r_den_reg <= s1_r_den_reg;
    end

    // stage 3: fix up the estimate by comparing the remainder with one and two divisors
    logic [F:0] omt;

    assign omt = (s2_rem_reg >= K45_X2) ? (s2_q_reg + (F+1)'(2)) :
                 (s2_rem_reg >= (F+1)'(K45)) ? (s2_q_reg + (F+1)'(1)) : s2_q_reg;

    logic          s3_vld_reg;
    logic [XW-1:0] s3_x_reg;
    logic          s3_fe_reg;
    logic          s3_byp_reg;
    logic [F:0]    s3_omt_reg;
    logic [2*F:0]  s3_r_num_reg;
    logic [F-1:0]  s3_r_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_x_reg     <= s2_x_reg;
        s3_fe_reg    <= s2_fe_reg;
        s3_byp_reg   <= s2_byp_reg;
        s3_omt_reg   <= omt;
        s3_r_num_reg <= s2_r_num_reg;
        s3_r_den_reg <= s2_r_den_reg;
    end

    // x over x plus 0.12, the (0.45-x)/0.45 estimate rides along in the tag
    logic          r_vld;
    logic [F:0]    r_q;
    logic [TW-1:0] r_tag;

    ltm_div #(.NW(2*F+1), .DW(F), .QW(F+1), .PW(TW)) u_div_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_vld_reg),
        .num       (s3_r_num_reg),
        .den       (s3_r_den_reg),
        .tag_in    ({s3_x_reg, s3_fe_reg, s3_byp_reg, s3_omt_reg}),
        .out_valid (r_vld),
        .quo       (r_q),
        .tag_out   (r_tag)
    );

    // stage 4: falloff squared
    logic [2*F+1:0] fall_prod;
    logic           s4_vld_reg;
    logic [XW-1:0]  s4_x_reg;
    logic           s4_fe_reg;
    logic           s4_byp_reg;
    logic [F:0]     s4_fall_reg;
    logic [F:0]     s4_r_reg;

    assign fall_prod = (2*F+2)'(r_tag[F:0]) * (2*F+2)'(r_tag[F:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            s4_vld_reg <= r_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_x_reg    <= r_tag[TW-1:F+3];
        s4_fe_reg   <= r_tag[F+2];
        s4_byp_reg  <= r_tag[F+1];
        s4_fall_reg <= (F+1)'((fall_prod + (2*F+2)'(HALF)) >> F);
        s4_r_reg    <= r_q;
    end

    // stage 5: lift shape
    logic [2*F+1:0] l_prod;
    logic           s5_vld_reg;
    logic [XW-1:0]  s5_x_reg;
    logic           s5_fe_reg;
    logic           s5_byp_reg;
    logic [F:0]     s5_l_reg;

    assign l_prod = (2*F+2)'(s4_fall_reg) * (2*F+2)'(s4_r_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_vld_reg <= 1'b0;
        end
        else
        begin
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s5_x_reg   <= s4_x_reg;
        s5_fe_reg  <= s4_fe_reg;
        s5_byp_reg <= s4_byp_reg;
        s5_l_reg   <= (F+1)'((l_prod + (2*F+2)'(HALF)) >> F);
    end

    // stage 6: add the lift, or pass x through when bypassed
    logic [2*F+3:0] add_prod;
    logic [F+2:0]   add_val;
    logic           s6_vld_reg;
    logic [XW-1:0]  s6_x_reg;
    logic           s6_fe_reg;

    assign add_prod = (2*F+4)'(p_reg) * (2*F+4)'(s5_l_reg);
    assign add_val  = (F+3)'((add_prod + (2*F+4)'(HALF)) >> F);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_vld_reg <= 1'b0;
        end
        else
        begin
            s6_vld_reg <= s5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s6_x_reg  <= s5_byp_reg ? s5_x_reg : (s5_x_reg + XW'(add_val));
        s6_fe_reg <= s5_fe_reg;
    end

    assign out_valid = s6_vld_reg;
    assign out_x     = s6_x_reg;
    assign out_fe    = s6_fe_reg;

endmodule

FILE: rtl/core/ltm_highlight.sv
// soft-knee highlight roll-off above the knee, fixed latency
// depends on ltm_pkg and ltm_div

module ltm_highlight
    import ltm_pkg::*;
#(
    parameter int F = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [F+4:0]     in_x,
    input  logic             in_fe,
    input  logic             enable,
    input  logic [CFG_W-1:0] knee,
    output logic             out_valid,
    output logic [F+4:0]     out_x,
    output logic             out_fe
);

    localparam int XW = F + 5;
    localparam longint unsigned ONE_L  = 64'd1 << F;
    localparam longint unsigned K001_L = ((64'd1 << F) + 64'd500) / 64'd1000;
    localparam logic [F:0]   ONE  = (F+1)'(ONE_L);
    localparam logic [F-1:0] K001 = F'(K001_L);

    // knee in internal format, headroom and small-headroom flag
    logic [F+16:0] knee_ext;
    logic [F:0]    k_reg;
    logic [F:0]    h_reg;
    logic          hs_reg;

    assign knee_ext = (F+17)'({knee, {F{1'b0}}}) + (F+17)'(32768);

    always_ff @(posedge clk)
    begin
        k_reg  <= (F+1)'(knee_ext >> 16);
        h_reg  <= ONE - (F+1)'(knee_ext >> 16);
        hs_reg <= (ONE - (F+1)'(knee_ext >> 16)) <= (F+1)'(K001);
    end

    // stage 1: excess over the knee and dividend
    logic           le;
    logic           byp;
    logic           pin;
    logic [XW-1:0]  e;
    logic [XW:0]    den;
    logic [2*F+6:0] num;

    assign le  = in_x <= XW'(k_reg);
    assign byp = !enable || le;
    assign pin = enable && !le && hs_reg;
    assign e   = in_x - XW'(k_reg);
    assign den = (XW+1)'(e) + (XW+1)'(h_reg);
    assign num = (byp || pin) ? '0 :
                 ((2*F+7)'(e) * (2*F+7)'(h_reg) + (2*F+7)'(den >> 1));

    logic           h1_vld_reg;
    logic [XW-1:0]  h1_x_reg;
    logic           h1_fe_reg;
    logic           h1_byp_reg;
    logic           h1_pin_reg;
    logic [2*F+6:0] h1_num_reg;
    logic [XW:0]    h1_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h1_vld_reg <= 1'b0;
        end
        else
        begin
            h1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        h1_x_reg   <= in_x;
        h1_fe_reg  <= in_fe;
        h1_byp_reg <= byp;
        h1_pin_reg <= pin;
        h1_num_reg <= num;
        h1_den_reg <= den;
    end

    logic          dv_vld;
    logic [F:0]    dv_q;
    logic [XW+2:0] dv_tag;

    ltm_div #(.NW(2*F+7), .DW(XW+1), .QW(F+1), .PW(XW+3)) u_div_knee (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (h1_vld_reg),
        .num       (h1_num_reg),
        .den       (h1_den_reg),
        .tag_in    ({h1_x_reg, h1_fe_reg, h1_byp_reg, h1_pin_reg}),
        .out_valid (dv_vld),
        .quo       (dv_q),
        .tag_out   (dv_tag)
    );

    // stage 2: pick passthrough, knee or rolled-off value
    logic          h2_vld_reg;
    logic [XW-1:0] h2_x_reg;
    logic          h2_fe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h2_vld_reg <= 1'b0;
        end
        else
        begin
            h2_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dv_tag[1])
        begin
            h2_x_reg <= dv_tag[XW+2:3];
        end
        else if (dv_tag[0])
        begin
            h2_x_reg <= XW'(k_reg);
        end
        else
        begin
            h2_x_reg <= XW'(k_reg) + XW'(dv_q);
        end
        h2_fe_reg <= dv_tag[2];
    end

    assign out_valid = h2_vld_reg;
    assign out_x     = h2_x_reg;
    assign out_fe    = h2_fe_reg;

endmodule

FILE: rtl/core/ltm_filmic.sv
// aces filmic rational curve, clamp to one and scale to q8.8
// depends on ltm_pkg and ltm_div

module ltm_filmic
    import ltm_pkg::*;
#(
    parameter int F = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [F+4:0]     in_x,
    input  logic             in_fe,
    output logic             out_valid,
    output logic [OUT_W-1:0] out_luma,
    output logic             out_fe
);

    localparam int XW = F + 5;
    localparam int TW = F + 7;
    localparam int NW = F + 12;
    localparam longint unsigned ONE_L = 64'd1 << F;
    localparam longint unsigned KA_L = ((64'd251 << F) + 64'd50) / 64'd100;
    localparam longint unsigned KB_L = ((64'd3 << F) + 64'd50) / 64'd100;
    localparam longint unsigned KC_L = ((64'd243 << F) + 64'd50) / 64'd100;
    localparam longint unsigned KD_L = ((64'd59 << F) + 64'd50) / 64'd100;
    localparam longint unsigned KE_L = ((64'd14 << F) + 64'd50) / 64'd100;
    localparam logic [F+1:0] KA = (F+2)'(KA_L);
    localparam logic [F+1:0] KC = (F+2)'(KC_L);
    localparam logic [F-1:0] KB = F'(KB_L);
    localparam logic [F-1:0] KD = F'(KD_L);
    localparam logic [F-1:0] KE = F'(KE_L);
    localparam logic [F:0]   ONE  = (F+1)'(ONE_L);
    localparam logic [F-1:0] HALF = F'(ONE_L >> 1);

    // stage 1: linear terms
    logic [2*F+6:0] pa;
    logic [2*F+6:0] pc;
    logic           f1_vld_reg;
    logic [XW-1:0]  f1_x_reg;
    logic           f1_fe_reg;
    logic [TW-1:0]  f1_tn_reg;
    logic [TW-1:0]  f1_td_reg;

    assign pa = (2*F+7)'(KA) * (2*F+7)'(in_x);
    assign pc = (2*F+7)'(KC) * (2*F+7)'(in_x);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
        end
        else
        begin
            f1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_x_reg  <= in_x;
        f1_fe_reg <= in_fe;
        f1_tn_reg <= TW'((pa + (2*F+7)'(HALF)) >> F) + TW'(KB);
        f1_td_reg <= TW'((pc + (2*F+7)'(HALF)) >> F) + TW'(KD);
    end

    // stage 2: numerator and denominator
    logic [2*F+11:0] pn;
    logic [2*F+11:0] pd;
    logic            f2_vld_reg;
    logic            f2_fe_reg;
    logic [NW-1:0]   f2_n_reg;
    logic [NW-1:0]   f2_d_reg;

    assign pn = (2*F+12)'(f1_tn_reg) * (2*F+12)'(f1_x_reg);
    assign pd = (2*F+12)'(f1_td_reg) * (2*F+12)'(f1_x_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f2_vld_reg <= 1'b0;
        end
        else
        begin
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f2_fe_reg <= f1_fe_reg;
        f2_n_reg  <= NW'((pn + (2*F+12)'(HALF)) >> F);
        f2_d_reg  <= NW'((pd + (2*F+12)'(HALF)) >> F) + NW'(KE);
    end

    // stage 3: clamp test and dividend
    logic            clamp;
    logic [2*F+12:0] f3_num;
    logic            f3_vld_reg;
    logic            f3_fe_reg;
    logic            f3_clamp_reg;
    logic [2*F+12:0] f3_num_reg;
    logic [NW-1:0]   f3_den_reg;

    assign clamp  = f2_n_reg >= f2_d_reg;
    assign f3_num = clamp ? '0 :
                    ((2*F+13)'({f2_n_reg, {F{1'b0}}}) + (2*F+13)'(f2_d_reg >> 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f3_vld_reg <= 1'b0;
        end
        else
        begin
            f3_vld_reg <= f2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f3_fe_reg    <= f2_fe_reg;
        f3_clamp_reg <= clamp;
        f3_num_reg   <= f3_num;
        f3_den_reg   <= f2_d_reg;
    end

    logic       dv_vld;
    logic [F:0] dv_q;
    logic [1:0] dv_tag;

    ltm_div #(.NW(2*F+13), .DW(NW), .QW(F+1), .PW(2)) u_div_curve (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f3_vld_reg),
        .num       (f3_num_reg),
        .den       (f3_den_reg),
        .tag_in    ({f3_fe_reg, f3_clamp_reg}),
        .out_valid (dv_vld),
        .quo       (dv_q),
        .tag_out   (dv_tag)
    );

    // stage 4: scale to q8.8
    logic [F:0]    v;
    logic [F+16:0] scaled;
    logic          f4_vld_reg;
    logic          f4_fe_reg;
    logic [OUT_W-1:0] f4_luma_reg;

    assign v      = dv_tag[0] ? ONE : dv_q;
    assign scaled = (F+17)'(v) * (F+17)'(OUT_SCALE) + (F+17)'(HALF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f4_vld_reg <= 1'b0;
        end
        else
        begin
            f4_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        f4_fe_reg   <= dv_tag[1];
        f4_luma_reg <= OUT_W'(scaled >> F);
    end

    assign out_valid = f4_vld_reg;
    assign out_luma  = f4_luma_reg;
    assign out_fe    = f4_fe_reg;

endmodule

FILE: rtl/core/luma_tone_mapper.sv
// luma tone mapper top: config registers, exposure stage and the stage chain
// three pipelined dividers in a row; uses ltm_pkg, ltm_shadow, ltm_highlight, ltm_filmic
// throughput one word per cycle; busy is always low and done marks each output word
// reset clears valid bits and loads the config registers with their defaults, no clearing pass

module luma_tone_mapper
    import ltm_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    // pixel stream
    input  logic              start,
    output logic              busy,
    input  pix_in_t           pixel,
    output logic              done,
    output pix_out_t          result,
    // config port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready
);

    localparam int F  = FRAC_BITS;
    localparam int XW = F + 5;

    // ------------------------------------------------------------------
    // config registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]     gain_reg;
    logic                 shadow_en_reg;
    logic [CFG_W-1:0]     lift_reg;
    logic                 hl_en_reg;
    logic [CFG_W-1:0]     knee_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= GAIN_RST;
            shadow_en_reg <= 1'b0;
            lift_reg      <= LIFT_RST;
            hl_en_reg     <= 1'b0;
            knee_reg      <= KNEE_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_EXPOSURE_GAIN:    gain_reg      <= pwdata[CFG_W-1:0];
                REG_SHADOW_ENABLE:    shadow_en_reg <= pwdata[0];
                REG_SHADOW_LIFT:      lift_reg      <= pwdata[CFG_W-1:0];
                REG_HIGHLIGHT_ENABLE: hl_en_reg     <= pwdata[0];
                REG_HIGHLIGHT_KNEE:   knee_reg      <= pwdata[CFG_W-1:0];
                default:              ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_idx)
            REG_EXPOSURE_GAIN:    prdata = APB_W'(gain_reg);
            REG_SHADOW_ENABLE:    prdata = APB_W'(shadow_en_reg);
            REG_SHADOW_LIFT:      prdata = APB_W'(lift_reg);
            REG_HIGHLIGHT_ENABLE: prdata = APB_W'(hl_en_reg);
            REG_HIGHLIGHT_KNEE:   prdata = APB_W'(knee_reg);
            default:              prdata = '0;
        endcase
    end

    // the pipeline never holds off a word
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // exposure: x = round(luma * gain * 2^F / (255 * 4096))
    // with p = luma*gain = 255*q + r this is (q << (F-12)) + ((r << (F-12)) + 127) / 255
    // both divides by 255 are reciprocal multiplies, exact over their ranges
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]    gain_eff;
    logic [48:0]         quo_prod;
    logic [23:0]         quo_back;
    logic [19:0]         frac_num;
    logic [40:0]         frac_prod;
    logic                e1_vld_reg;
    logic                e1_fe_reg;
    logic [23:0]         e1_prod_reg;
    logic                e2_vld_reg;
    logic                e2_fe_reg;
    logic [23:0]         e2_prod_reg;
    logic [16:0]         e2_quo_reg;
    logic                e3_vld_reg;
    logic                e3_fe_reg;
    logic [16:0]         e3_quo_reg;
    logic [7:0]          e3_rem_reg;
    logic                e4_vld_reg;
    logic                e4_fe_reg;
    logic [XW-1:0]       e4_x_reg;

    // gain floor at about 0.1
    assign gain_eff = (gain_reg < GAIN_MIN) ? GAIN_MIN : gain_reg;

    assign quo_prod  = 49'(e1_prod_reg) * 49'(RECIP_255_24);
    assign quo_back  = 24'({e2_quo_reg, 8'h00}) - 24'(e2_quo_reg);
    assign frac_num  = (20'(e3_rem_reg) << (F - 12)) + 20'(LUMA_ROUND);
    assign frac_prod = 41'(frac_num) * 41'(RECIP_255_20);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_vld_reg <= 1'b0;
            e2_vld_reg <= 1'b0;
            e3_vld_reg <= 1'b0;
            e4_vld_reg <= 1'b0;
        end
        else
        begin
            e1_vld_reg <= start & ~busy;
            e2_vld_reg <= e1_vld_reg;
            e3_vld_reg <= e2_vld_reg;
            e4_vld_reg <= e3_vld_reg;
        end
    end

    // quotient stays below 16.0, so F+5 bits carry it
    always_ff @(posedge clk)
    begin
        e1_fe_reg   <= pixel.frame_end_in;
        e1_prod_reg <= 24'(pixel.luma_in) * 24'(gain_eff);
        e2_fe_reg   <= e1_fe_reg;
        e2_prod_reg <= e1_prod_reg;
        e2_quo_reg  <= 17'(quo_prod >> 32);
        e3_fe_reg   <= e2_fe_reg;
        e3_quo_reg  <= e2_quo_reg;
        e3_rem_reg  <= 8'(e2_prod_reg - quo_back);
        e4_fe_reg   <= e3_fe_reg;
        e4_x_reg    <= (XW'(e3_quo_reg) << (F - 12)) + XW'(frac_prod >> 28);
    end

    logic          ex_vld;
    logic [XW-1:0] ex_x;
    logic          ex_fe;

    assign ex_vld = e4_vld_reg;
    assign ex_x   = e4_x_reg;
    assign ex_fe  = e4_fe_reg;

    // ------------------------------------------------------------------
    // shadow lift, highlight knee, filmic curve
    // each stage keeps its latency whether enabled or not, so words stay in order
    // ------------------------------------------------------------------
    logic          sh_vld;
    logic [XW-1:0] sh_x;
    logic          sh_fe;
    logic          hl_vld;
    logic [XW-1:0] hl_x;
    logic          hl_fe;
    logic          fm_vld;
    logic [OUT_W-1:0] fm_luma;
    logic          fm_fe;

    ltm_shadow #(.F(F)) u_shadow (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ex_vld),
        .in_x      (ex_x),
        .in_fe     (ex_fe),
        .enable    (shadow_en_reg),
        .lift      (lift_reg),
        .out_valid (sh_vld),
        .out_x     (sh_x),
        .out_fe    (sh_fe)
    );

    ltm_highlight #(.F(F)) u_highlight (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sh_vld),
        .in_x      (sh_x),
        .in_fe     (sh_fe),
        .enable    (hl_en_reg),
        .knee      (knee_reg),
        .out_valid (hl_vld),
        .out_x     (hl_x),
        .out_fe    (hl_fe)
    );

    ltm_filmic #(.F(F)) u_filmic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hl_vld),
        .in_x      (hl_x),
        .in_fe     (hl_fe),
        .out_valid (fm_vld),
        .out_luma  (fm_luma),
        .out_fe    (fm_fe)
    );

    // result word straight from the last pipeline register
    assign done                 = fm_vld;
    assign result.luma_out      = fm_luma;
    assign result.frame_end_out = fm_fe;

endmodule

FILE: sim/ltm_checker.sv
// checker for the luma tone mapper: watches the pixel and config channels,
// predicts each output word in fixed point and compares; depends on ltm_pkg
`timescale 1ns / 1ps

module ltm_checker
    import ltm_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  pix_in_t           pixel,
    input  logic              done,
    input  pix_out_t          result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    input  logic              pready,
    output int                fail_count,
    output int                pending
);

    localparam longint ONE  = 64'd1 << FRAC_BITS;
    localparam longint HALF = 64'd1 << (FRAC_BITS - 1);
    localparam longint XMAX = (64'd32 << FRAC_BITS) - 1;

    function automatic longint fx_const(longint n, longint d);
        return ((n << FRAC_BITS) + d / 2) / d;
    endfunction

    localparam longint K45  = fx_const(45, 100);
    localparam longint K12  = fx_const(12, 100);
    localparam longint K22  = fx_const(22, 100);
    localparam longint K001 = fx_const(1, 1000);
    localparam longint KA   = fx_const(251, 100);
    localparam longint KB   = fx_const(3, 100);
    localparam longint KC   = fx_const(243, 100);
    localparam longint KD   = fx_const(59, 100);
    localparam longint KE   = fx_const(14, 100);

    // shadow copy of the config registers
    logic [CFG_W-1:0] gain_q, lift_q, knee_q;
    logic             shadow_on, highlight_on;

    pix_out_t expected_words[$];

    function automatic longint div_rnd(longint a, longint b);
        return (b != 0) ? (a + b / 2) / b : 0;
    endfunction

    function automatic longint shr_rnd(longint a);
        return (a + HALF) >>> FRAC_BITS;
    endfunction

    function automatic longint clip(longint a);
        return (a > XMAX) ? XMAX : a;
    endfunction

    function automatic pix_out_t tone_map(pix_in_t px);
        longint g, x, omt, fall, r, l, p, k, h, e, n, d, v;
        pix_out_t o;
        g = (gain_q < GAIN_MIN) ? GAIN_MIN : gain_q;
        x = clip(div_rnd(longint'(px.luma_in) * g * ONE, 255 * 4096));
        if (shadow_on && x != 0 && x < K45 && lift_q != 0)
        begin
            omt  = div_rnd((K45 - x) * ONE, K45);
            fall = shr_rnd(omt * omt);
            r    = div_rnd(x * ONE, x + K12);
            l    = shr_rnd(fall * r);
            p    = (longint'(lift_q) * K22 + 2048) >>> 12;
            x    = clip(x + shr_rnd(p * l));
        end
        if (highlight_on)
        begin
            k = (longint'(knee_q) * ONE + 32768) >>> 16;
            if (x > k)
            begin
                h = ONE - k;
                if (h <= K001)
                    x = k;
                else
                begin
                    e = x - k;
                    x = k + div_rnd(e * h, e + h);
                end
            end
        end
        n = shr_rnd((shr_rnd(KA * x) + KB) * x);
        d = shr_rnd((shr_rnd(KC * x) + KD) * x) + KE;
        v = (n >= d) ? ONE : div_rnd(n * ONE, d);
        o.luma_out      = 16'((v * 255 * 256 + HALF) >>> FRAC_BITS);
        o.frame_end_out = px.frame_end_in;
        return o;
    endfunction

    assign pending = expected_words.size();

    always @(posedge clk or negedge rst_n)
    begin
        pix_out_t want;
        if (!rst_n)
        begin
            gain_q       <= GAIN_RST;
            lift_q       <= LIFT_RST;
            knee_q       <= KNEE_RST;
            shadow_on    <= 1'b0;
            highlight_on <= 1'b0;
            fail_count   <= 0;
            expected_words.delete();
        end
        else
        begin
            // output side first: a word accepted now was predicted earlier
            if (done)
            begin
                if (expected_words.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected word luma=%0d fe=%0b",
                                 result.luma_out, result.frame_end_out);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (want !== result)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: exp luma=%0d fe=%0b, got luma=%0d fe=%0b",
                                     want.luma_out, want.frame_end_out,
                                     result.luma_out, result.frame_end_out);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                expected_words.push_back(tone_map(pixel));
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_EXPOSURE_GAIN:    gain_q       <= pwdata[CFG_W-1:0];
                    REG_SHADOW_ENABLE:    shadow_on    <= pwdata[0];
                    REG_SHADOW_LIFT:      lift_q       <= pwdata[CFG_W-1:0];
                    REG_HIGHLIGHT_ENABLE: highlight_on <= pwdata[0];
                    REG_HIGHLIGHT_KNEE:   knee_q       <= pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: sim/tb.sv
// testbench top for the luma tone mapper: clock, reset, pixel and config stimulus
// the verdict comes from ltm_checker; depends on ltm_pkg and the block's rtl
`timescale 1ns / 1ps

module tb;
    import ltm_pkg::*;

    localparam int LATENCY   = 67;
    localparam int STALL_MAX = 2000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    pix_in_t           pixel;
    logic              done;
    pix_out_t          result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_W-1:0]  pwdata;
    logic [APB_W-1:0]  prdata;
    logic              pready;
    int                fail_count;
    int                pending;
    int                quiet_cycles;
    bit                idle_ok;

    luma_tone_mapper u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .pixel   (pixel),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ltm_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .pixel      (pixel),
        .done       (done),
        .result     (result),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog: counts cycles with neither a pixel nor an output word moving
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // apb write: setup cycle then access cycle; the caller ends the transfer
    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    // drain the pipe before touching config: all words out, then the latency
    task automatic drain_pipe();
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_config(logic [15:0] gain, bit sh_en, logic [15:0] lift,
                              bit hl_en, logic [15:0] knee);
        drain_pipe();
        write_reg(REG_EXPOSURE_GAIN, {16'h0, gain});
        write_reg(REG_SHADOW_ENABLE, {31'h0, sh_en});
        write_reg(REG_SHADOW_LIFT, {16'h0, lift});
        write_reg(REG_HIGHLIGHT_ENABLE, {31'h0, hl_en});
        write_reg(REG_HIGHLIGHT_KNEE, {16'h0, knee});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // offers one word, holding start until it is taken; optional idle gap first
    task automatic send_pixel(logic [7:0] luma, bit fe);
        if (idle_ok)
        begin
            while ($urandom_range(99) < 35)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start        <= 1'b1;
        pixel.luma_in      <= luma;
        pixel.frame_end_in <= fe;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // random luma, biased toward the ends and the shadow band
    function automatic logic [7:0] pick_luma();
        case ($urandom_range(3))
            0: return 8'($urandom_range(15));
            1: return 8'($urandom_range(255, 240));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [15:0] pick_cfg16();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(420, 400));
            3: return 16'($urandom_range(65535, 65400));
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        pixel   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        idle_ok = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset config, input extremes and all-ones bits
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd128, 1'b1);
        start <= 1'b0;

        // gain below the floor, shadow at max lift, knee near one (no headroom)
        set_config(16'd0, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd100, 1'b1);
        send_pixel(8'd255, 1'b0);
        start <= 1'b0;

        // max gain pushes x toward its top; zero lift; knee at zero
        set_config(16'hFFFF, 1'b1, 16'd0, 1'b1, 16'd0);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd2, 1'b0);
        send_pixel(8'd255, 1'b1);
        start <= 1'b0;

        // unity gain, shadow on, default knee: values across both bends
        set_config(16'd4096, 1'b1, 16'd4096, 1'b1, 16'd52429);
        send_pixel(8'd30, 1'b0);
        send_pixel(8'd114, 1'b0);
        send_pixel(8'd115, 1'b0);
        send_pixel(8'd204, 1'b0);
        send_pixel(8'd240, 1'b1);
        start <= 1'b0;

        // random phases, each with its own config; the first one never idles
        for (int ph = 0; ph < 17; ph++)
        begin
            set_config(pick_cfg16(), 1'($urandom_range(1)), pick_cfg16(),
                       1'($urandom_range(1)), pick_cfg16());
            idle_ok = (ph != 0);
            for (int i = 0; i < 50; i++)
            begin
                send_pixel(pick_luma(), ($urandom_range(15) == 0));
                // once, mid-way through phase 3, the sender waits for every word in flight
                if (i == 25 && ph == 3)
                begin
                    start <= 1'b0;
                    @(posedge clk);
                    while (pending != 0)
                        @(posedge clk);
                end
            end
            start <= 1'b0;
        end

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
